// ===== hdl/acse_pkg.sv =====
package acse_pkg;

  localparam int unsigned STEP_W = 4;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned PROD_W  = 64;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] VALPHA_RST = 17'd6554;
  localparam logic [16:0] CALPHA_RST = 17'd22938;
  localparam logic [2:0]  RANGE_RST  = 3'd1;
  localparam logic [23:0] GAIN_RST   = 24'd2890295;

  localparam logic [2:0] RANGE_MAX = 3'd5;
  localparam logic [2:0] TAP_LAST  = 3'd5;

  localparam logic [27:0] BATTERY_FACTOR = 28'd168346764;
  localparam logic [27:0] SHUNT_FACTOR   = 28'd168660247;
  localparam logic [27:0] BUCK_FACTOR    = 28'd169449882;

  // volts = round(mag * factor * k / (125 * 2^18)), k = full scale / 256 mV
  localparam logic [49:0] SCALE_HALF  = 50'd16384000;
  localparam int unsigned SCALE_SHIFT = 18;
  localparam logic [29:0] RECIP_125   = 30'd549755814;
  localparam int unsigned RECIP_SHIFT = 36;

  localparam logic signed [63:0] HALF_Q16 = 64'sd32768;
  localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

  typedef enum logic [1:0] {
    CFG_VOLTAGE_ALPHA,
    CFG_CURRENT_ALPHA,
    CFG_RANGE_SELECT,
    CFG_CURRENT_GAIN
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TAP,
    KIND_BATTERY,
    KIND_SHUNT,
    KIND_BUCK
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_MAG,
    OP_SCALE_K,
    OP_MUL_RECIP,
    OP_SIGN,
    OP_EMA_DIFF,
    OP_EMA_SUM,
    OP_CUR_MUL,
    OP_CUR_RND
  } op_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_BAD_CH,
    JC_NO_CUR
  } jcond_t;

  typedef struct packed {
    op_t               op;
    logic              wait_in;
    logic              wait_out;
    jcond_t            jc;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic take_in;
  } ctl_t;

  typedef struct packed {
    logic bad_ch;
    logic cur_pend;
    logic out_free;
  } stat_t;

  function automatic logic [27:0] tap_factor(input logic [2:0] idx);
    logic [27:0] f;
    case (idx)
      3'd0:    f = 28'd24001543;
      3'd1:    f = 28'd47056158;
      3'd2:    f = 28'd72148305;
      3'd3:    f = 28'd95555540;
      3'd4:    f = 28'd130794367;
      default: f = 28'd154350387;
    endcase
    return f;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/acse_useq.sv =====
module acse_useq
  import acse_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_MAG   = 4'd1;
  localparam logic [STEP_W-1:0] ST_SCALE_K   = 4'd2;
  localparam logic [STEP_W-1:0] ST_MUL_RECIP = 4'd3;
  localparam logic [STEP_W-1:0] ST_SIGN      = 4'd4;
  localparam logic [STEP_W-1:0] ST_EMA_DIFF  = 4'd5;
  localparam logic [STEP_W-1:0] ST_EMA_SUM   = 4'd6;
  localparam logic [STEP_W-1:0] ST_CUR_MUL   = 4'd7;
  localparam logic [STEP_W-1:0] ST_CUR_RND   = 4'd8;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      ST_IDLE:      w = '{OP_LOAD,      1'b1, 1'b0, JC_BAD_CH, ST_IDLE};
      ST_MUL_MAG:   w = '{OP_MUL_MAG,   1'b0, 1'b0, JC_NEXT,   ST_IDLE};
      ST_SCALE_K:   w = '{OP_SCALE_K,   1'b0, 1'b0, JC_NEXT,   ST_IDLE};
      ST_MUL_RECIP: w = '{OP_MUL_RECIP, 1'b0, 1'b0, JC_NEXT,   ST_IDLE};
      ST_SIGN:      w = '{OP_SIGN,      1'b0, 1'b0, JC_NEXT,   ST_IDLE};
      ST_EMA_DIFF:  w = '{OP_EMA_DIFF,  1'b0, 1'b0, JC_NEXT,   ST_IDLE};
      ST_EMA_SUM:   w = '{OP_EMA_SUM,   1'b0, 1'b1, JC_NO_CUR, ST_IDLE};
      ST_CUR_MUL:   w = '{OP_CUR_MUL,   1'b0, 1'b0, JC_NEXT,   ST_IDLE};
      ST_CUR_RND:   w = '{OP_CUR_RND,   1'b0, 1'b0, JC_ALWAYS, ST_EMA_DIFF};
      default:      w = '{OP_NOP,       1'b0, 1'b0, JC_ALWAYS, ST_IDLE};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step_r, step_nxt;
  uword_t            uw;
  logic              hold;
  logic              jump;

  always_comb begin
    uw   = ucode(step_r);
    hold = (uw.wait_in && !in_valid) || (uw.wait_out && !stat.out_free);
    unique case (uw.jc)
      JC_NEXT:   jump = 1'b0;
      JC_ALWAYS: jump = 1'b1;
      JC_BAD_CH: jump = stat.bad_ch;
      JC_NO_CUR: jump = !stat.cur_pend;
      default:   jump = 1'b1;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
    ctl.op      = hold ? OP_NOP : uw.op;
    ctl.take_in = uw.wait_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hdl/acse_datapath.sv =====
module acse_datapath
  import acse_pkg::*;
#(
  parameter int CELL_COUNT = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  input  logic [3:0]         in_channel,
  input  logic signed [15:0] in_raw_code,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               out_stall,
  output stat_t              stat,
  output logic               out_valid,
  output logic [3:0]         out_quantity,
  output logic signed [31:0] out_value,
  output logic signed [15:0] out_raw_echo,
  output logic               out_last
);

  localparam int QN = CELL_COUNT + 4;
  localparam int QW = $clog2(QN);
  localparam logic [4:0]    C_BAT   = 5'(CELL_COUNT);
  localparam logic [4:0]    C_SHUNT = 5'(CELL_COUNT + 1);
  localparam logic [4:0]    C_BUCK  = 5'(CELL_COUNT + 2);
  localparam logic [QW-1:0] Q_CUR   = QW'(CELL_COUNT + 3);

  logic [16:0] valpha_r, calpha_r;
  logic [2:0]  range_r;
  logic [23:0] gain_r;

  logic signed [15:0] raw_r;
  kind_t              kind_r;
  logic               tap0_r;
  logic [27:0]        factor_r;
  logic [QW-1:0]      q_idx_r;
  logic               cur_phase_r;
  logic signed [63:0] mul_r;
  logic [29:0]        t_r;
  logic signed [31:0] sample_r;
  logic signed [31:0] prev_r;
  logic signed [31:0] bat_r;
  logic signed [31:0] rd_r;
  logic signed [31:0] store [QN];
  logic [QN-1:0]      seen_r;

  logic               out_valid_r;
  logic [3:0]         out_quantity_r;
  logic signed [31:0] out_value_r;
  logic signed [15:0] out_raw_r;
  logic               out_last_r;

  logic [4:0]                 ch5;
  kind_t                      kind_in;
  logic [2:0]                 tap_idx;
  logic [27:0]                factor_in;
  logic signed [16:0]         raw_x;
  logic signed [16:0]         mag;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [64:0]         prod_full;
  logic [2:0]                 rsel;
  logic [49:0]                m_k, m_in, n_scaled;
  logic [23:0]                q_mag;
  logic signed [31:0]         q_val, volts;
  logic signed [31:0]         tap_diff, sample_in;
  logic signed [32:0]         delta, diff33, diff_pos;
  logic [16:0]                alpha_sel, alpha_eff;
  logic signed [63:0]         ema_sum;
  logic signed [31:0]         ema_res, result;
  logic signed [31:0]         cur_val;
  logic                       out_fire;
  logic                       mul_en;

  always_comb begin
    ch5     = {1'b0, in_channel};
    tap_idx = (in_channel > 4'(TAP_LAST)) ? TAP_LAST : in_channel[2:0];
    if (ch5 < C_BAT) begin
      kind_in   = KIND_TAP;
      factor_in = tap_factor(tap_idx);
    end else if (ch5 == C_BAT) begin
      kind_in   = KIND_BATTERY;
      factor_in = BATTERY_FACTOR;
    end else if (ch5 == C_SHUNT) begin
      kind_in   = KIND_SHUNT;
      factor_in = SHUNT_FACTOR;
    end else begin
      kind_in   = KIND_BUCK;
      factor_in = BUCK_FACTOR;
    end
  end

  always_comb begin
    raw_x     = 17'(raw_r);
    mag       = raw_r[15] ? -raw_x : raw_x;
    alpha_sel = cur_phase_r ? calpha_r : valpha_r;
    alpha_eff = (alpha_sel > ONE_Q16) ? ONE_Q16 : alpha_sel;
    delta     = 33'(sample_r) - 33'(rd_r);
    diff33    = 33'(sample_r) - 33'(bat_r);
    diff_pos  = (diff33 > 33'sd0) ? diff33 : 33'sd0;

    unique case (ctl.op)
      OP_MUL_MAG: begin
        mul_a = MUL_A_W'(mag);
        mul_b = $signed({3'b0, factor_r});
      end
      OP_MUL_RECIP: begin
        mul_a = $signed({4'b0, t_r});
        mul_b = $signed({1'b0, RECIP_125});
      end
      OP_EMA_DIFF: begin
        mul_a = MUL_A_W'(delta);
        mul_b = $signed({14'b0, alpha_eff});
      end
      OP_CUR_MUL: begin
        mul_a = MUL_A_W'(diff_pos);
        mul_b = $signed({7'b0, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_full = 65'(mul_a) * 65'(mul_b);
    mul_en    = (ctl.op == OP_MUL_MAG) || (ctl.op == OP_MUL_RECIP) ||
                (ctl.op == OP_EMA_DIFF) || (ctl.op == OP_CUR_MUL);
  end

  always_comb begin
    rsel = (range_r > RANGE_MAX) ? RANGE_MAX : range_r;
    m_in = mul_r[49:0];
    case (rsel)
      3'd0:    m_k = (m_in << 4) + (m_in << 3);
      3'd1:    m_k = m_in << 4;
      3'd2:    m_k = m_in << 3;
      3'd3:    m_k = m_in << 2;
      3'd4:    m_k = m_in << 1;
      default: m_k = m_in;
    endcase
    n_scaled = m_k + SCALE_HALF;

    q_mag    = mul_r[RECIP_SHIFT+23:RECIP_SHIFT];
    q_val    = $signed({8'b0, q_mag});
    volts    = raw_r[15] ? -q_val : q_val;
    tap_diff = sat32(64'(volts) - 64'(prev_r));
    if (kind_r == KIND_TAP && !tap0_r) begin
      sample_in = tap_diff;
    end else begin
      sample_in = volts;
    end

    ema_sum = mul_r + (64'(rd_r) <<< 16) + HALF_Q16;
    ema_res = sat32(ema_sum >>> 16);
    result  = seen_r[q_idx_r] ? ema_res : sample_r;
    cur_val = sat32((mul_r + HALF_Q16) >>> 16);
  end

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valpha_r    <= VALPHA_RST;
      calpha_r    <= CALPHA_RST;
      range_r     <= RANGE_RST;
      gain_r      <= GAIN_RST;
      prev_r      <= '0;
      bat_r       <= '0;
      seen_r      <= '0;
      cur_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_VOLTAGE_ALPHA: valpha_r <= cfg_wdata[16:0];
          CFG_CURRENT_ALPHA: calpha_r <= cfg_wdata[16:0];
          CFG_RANGE_SELECT:  range_r  <= cfg_wdata[2:0];
          CFG_CURRENT_GAIN:  gain_r   <= cfg_wdata;
          default:           gain_r   <= gain_r;
        endcase
      end
      if (ctl.op == OP_EMA_SUM) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.op)
        OP_LOAD: begin
          cur_phase_r <= 1'b0;
        end
        OP_SIGN: begin
          if (kind_r == KIND_TAP) begin
            prev_r <= volts;
          end
          if (kind_r == KIND_BATTERY) begin
            bat_r <= volts;
          end
        end
        OP_EMA_SUM: begin
          seen_r[q_idx_r] <= 1'b1;
        end
        OP_CUR_MUL: begin
          cur_phase_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_r <= prod_full[PROD_W-1:0];
    end
    case (ctl.op)
      OP_LOAD: begin
        raw_r    <= in_raw_code;
        kind_r   <= kind_in;
        tap0_r   <= (in_channel == 4'd0);
        factor_r <= factor_in;
        q_idx_r  <= QW'(in_channel);
      end
      OP_SCALE_K: begin
        t_r <= n_scaled[SCALE_SHIFT+29:SCALE_SHIFT];
      end
      OP_SIGN: begin
        sample_r <= sample_in;
        rd_r     <= store[q_idx_r];
      end
      OP_EMA_SUM: begin
        store[q_idx_r] <= result;
        out_quantity_r <= 4'(q_idx_r);
        out_value_r    <= result;
        out_raw_r      <= cur_phase_r ? 16'sd0 : raw_r;
        out_last_r     <= !(kind_r == KIND_SHUNT && !cur_phase_r);
      end
      OP_CUR_MUL: begin
        q_idx_r <= Q_CUR;
      end
      OP_CUR_RND: begin
        sample_r <= cur_val;
        rd_r     <= store[q_idx_r];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.bad_ch   = ch5 > C_BUCK;
    stat.cur_pend = (kind_r == KIND_SHUNT) && !cur_phase_r;
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid    = out_valid_r;
  assign out_quantity = out_quantity_r;
  assign out_value    = out_value_r;
  assign out_raw_echo = out_raw_r;
  assign out_last     = out_last_r;

endmodule

// ===== hdl/adc_channel_scale_ema_unit.sv =====
// channel | direction | ports                                             | transaction
// in      | input     | in_valid, in_stall, in_channel, in_raw_code       | valid & !stall
// out     | output    | out_valid, out_stall, out_quantity, out_value,    | valid & !stall
//         |           | out_raw_echo, out_last                            |
// cfg     | input     | cfg_we, cfg_index, cfg_wdata                      | we
//
// The microcode program steps each item through one shared multiplier, used three times per
// voltage and twice for current; a shunt item yields both results. An unknown channel is
// dropped at the idle step without a result.
// Synchronous active-low reset restores config defaults and clears the sequencer, tap and
// battery history, seen bits and output valid.
// A stalled output holds the sequencer at its write-back step; in_stall is low only idle.
module adc_channel_scale_ema_unit
  import acse_pkg::*;
#(
  parameter int CELL_COUNT = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_channel,
  input  logic signed [15:0] in_raw_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_quantity,
  output logic signed [31:0] out_value,
  output logic signed [15:0] out_raw_echo,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam logic [3:0] Q_SHUNT_CODE = 4'(CELL_COUNT + 1);

  ctl_t  ctl;
  stat_t stat;

  acse_useq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  acse_datapath #(
    .CELL_COUNT (CELL_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_channel   (in_channel),
    .in_raw_code  (in_raw_code),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_stall    (out_stall),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_quantity (out_quantity),
    .out_value    (out_value),
    .out_raw_echo (out_raw_echo),
    .out_last     (out_last)
  );

  assign in_stall = !ctl.take_in;

  a_first_of_two_is_shunt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |-> (out_quantity == Q_SHUNT_CODE))
    else $error("non-final result is not a shunt result");

  a_bad_channel_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && stat.bad_ch) |=> !in_stall)
    else $error("unknown channel did not return to idle");

  a_good_channel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !stat.bad_ch) |=> in_stall)
    else $error("input taken while an item is in progress");

endmodule
